### rtl/i2ccrb_pkg.sv
// Shared definitions for the I2C controller register block.
// Register offsets, status and control bit positions, and the result type.
// No dependencies.
package i2ccrb_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OFS_W  = 8;
    localparam int unsigned TXB_W  = 8;

    // Register offsets
    localparam logic [OFS_W-1:0] OFS_CTRL1   = 8'h00;
    localparam logic [OFS_W-1:0] OFS_CTRL2   = 8'h04;
    localparam logic [OFS_W-1:0] OFS_OAR1    = 8'h08;
    localparam logic [OFS_W-1:0] OFS_OAR2    = 8'h0C;
    localparam logic [OFS_W-1:0] OFS_TIMING  = 8'h10;
    localparam logic [OFS_W-1:0] OFS_TIMEOUT = 8'h14;
    localparam logic [OFS_W-1:0] OFS_STATUS  = 8'h18;
    localparam logic [OFS_W-1:0] OFS_CLEAR   = 8'h1C;
    localparam logic [OFS_W-1:0] OFS_PEC     = 8'h20;
    localparam logic [OFS_W-1:0] OFS_RXDATA  = 8'h24;
    localparam logic [OFS_W-1:0] OFS_TXDATA  = 8'h28;

    // Access kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Status bits
    localparam logic [DATA_W-1:0] STATUS_RESET = 32'h0000_0001;
    localparam logic [DATA_W-1:0] ST_TXE   = 32'h0000_0001;
    localparam logic [DATA_W-1:0] ST_TXIS  = 32'h0000_0002;
    localparam logic [DATA_W-1:0] ST_RXNE  = 32'h0000_0004;
    localparam logic [DATA_W-1:0] ST_STOPF = 32'h0000_0020;
    localparam logic [DATA_W-1:0] ST_BUSY  = 32'h0000_8000;

    // Control bit positions
    localparam int unsigned CR1_PE_BIT     = 0;
    localparam int unsigned CR1_TXIE_BIT   = 1;
    localparam int unsigned CR1_STOPIE_BIT = 5;
    localparam int unsigned CR2_START_BIT  = 13;
    localparam int unsigned CR2_STOP_BIT   = 14;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_raise;
    } rsp_t;

endpackage

### rtl/i2ccrb_if.sv
// Valid/ready channel interfaces for the I2C controller register block.
// Depends on i2ccrb_pkg for field widths.
interface i2ccrb_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [i2ccrb_pkg::OFS_W-1:0]     reg_offset;
    logic [i2ccrb_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, output req_type, output reg_offset, output write_data,
                    input ready);
    modport sink   (input valid, input req_type, input reg_offset, input write_data,
                    output ready);
endinterface

interface i2ccrb_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [i2ccrb_pkg::DATA_W-1:0]    read_data;
    logic                             irq_raise;

    modport source (output valid, output read_data, output irq_raise, input ready);
    modport sink   (input valid, input read_data, input irq_raise, output ready);
endinterface

### rtl/i2c_controller_register_block.sv
// Register file of an I2C controller: decodes one bus access per transaction.
// Depends on i2ccrb_pkg and the channel interfaces in i2ccrb_if.sv.
//
//   channel | dir | payload                                 | handshake
//   --------+-----+-----------------------------------------+-------------
//   req     | in  | req_type, reg_offset, write_data        | valid/ready
//   rsp     | out | read_data, irq_raise                    | valid/ready
//
// One access per cycle while req.ready is high: decode and register update finish
// in the accept cycle; the result is registered in the output or the skid register.
// Register state commits at acceptance; results queue in an output register
// plus a one-entry skid register, so req stays ready while one result waits.
// req.ready drops only when both are full; it is a register, not a path from rsp.ready.
// Asynchronous active-low reset: status reads 1, other state 0; result data not reset.
module i2c_controller_register_block
(
    input  logic                clk,
    input  logic                rst_n,
    i2ccrb_req_if.sink          req,
    i2ccrb_rsp_if.source        rsp
);

    logic [i2ccrb_pkg::DATA_W-1:0] ctrl1_reg, ctrl1_next;
    logic [i2ccrb_pkg::DATA_W-1:0] ctrl2_reg, ctrl2_next;
    logic [i2ccrb_pkg::DATA_W-1:0] oar1_reg, oar1_next;
    logic [i2ccrb_pkg::DATA_W-1:0] oar2_reg, oar2_next;
    logic [i2ccrb_pkg::DATA_W-1:0] timing_reg, timing_next;
    logic [i2ccrb_pkg::DATA_W-1:0] timeout_reg, timeout_next;
    logic [i2ccrb_pkg::DATA_W-1:0] status_reg, status_next;
    logic [i2ccrb_pkg::TXB_W-1:0]  txbyte_reg, txbyte_next;

    i2ccrb_pkg::rsp_t result;
    i2ccrb_pkg::rsp_t out_reg, out_next;
    i2ccrb_pkg::rsp_t skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             accept;
    logic             out_stall;

    assign req.ready = !skid_valid_reg;
    assign accept    = req.valid && req.ready;
    assign out_stall = out_valid_reg && !rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_reg.read_data;
    assign rsp.irq_raise = out_reg.irq_raise;

    // Decode and register update
    always_comb
    begin
        logic [i2ccrb_pkg::DATA_W-1:0] st;
        st           = status_reg;
        ctrl1_next   = ctrl1_reg;
        ctrl2_next   = ctrl2_reg;
        oar1_next    = oar1_reg;
        oar2_next    = oar2_reg;
        timing_next  = timing_reg;
        timeout_next = timeout_reg;
        txbyte_next  = txbyte_reg;
        result       = '0;

        if (req.req_type == i2ccrb_pkg::REQ_WRITE)
        begin
            unique case (req.reg_offset)
                i2ccrb_pkg::OFS_CTRL1:
                begin
                    ctrl1_next = req.write_data;
                    if (!req.write_data[i2ccrb_pkg::CR1_PE_BIT])
                    begin
                        st = i2ccrb_pkg::STATUS_RESET;
                    end
                end
                i2ccrb_pkg::OFS_CTRL2:
                begin
                    ctrl2_next = req.write_data;
                    // START first, then STOP
                    if (req.write_data[i2ccrb_pkg::CR2_START_BIT])
                    begin
                        st = (st | i2ccrb_pkg::ST_BUSY | i2ccrb_pkg::ST_TXIS)
                             & ~i2ccrb_pkg::ST_STOPF;
                    end
                    if (req.write_data[i2ccrb_pkg::CR2_STOP_BIT])
                    begin
                        st = (st & ~i2ccrb_pkg::ST_BUSY) | i2ccrb_pkg::ST_STOPF;
                        result.irq_raise = ctrl1_reg[i2ccrb_pkg::CR1_STOPIE_BIT];
                    end
                end
                i2ccrb_pkg::OFS_OAR1:    oar1_next    = req.write_data;
                i2ccrb_pkg::OFS_OAR2:    oar2_next    = req.write_data;
                i2ccrb_pkg::OFS_TIMING:  timing_next  = req.write_data;
                i2ccrb_pkg::OFS_TIMEOUT: timeout_next = req.write_data;
                i2ccrb_pkg::OFS_CLEAR:   st = st & ~req.write_data;
                i2ccrb_pkg::OFS_TXDATA:
                begin
                    txbyte_next = req.write_data[i2ccrb_pkg::TXB_W-1:0];
                    st = st | i2ccrb_pkg::ST_TXE | i2ccrb_pkg::ST_TXIS;
                    result.irq_raise = ctrl1_reg[i2ccrb_pkg::CR1_TXIE_BIT];
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (req.reg_offset)
                i2ccrb_pkg::OFS_CTRL1:   result.read_data = ctrl1_reg;
                i2ccrb_pkg::OFS_CTRL2:   result.read_data = ctrl2_reg;
                i2ccrb_pkg::OFS_OAR1:    result.read_data = oar1_reg;
                i2ccrb_pkg::OFS_OAR2:    result.read_data = oar2_reg;
                i2ccrb_pkg::OFS_TIMING:  result.read_data = timing_reg;
                i2ccrb_pkg::OFS_TIMEOUT: result.read_data = timeout_reg;
                i2ccrb_pkg::OFS_STATUS:  result.read_data = status_reg;
                i2ccrb_pkg::OFS_RXDATA:  st = st & ~i2ccrb_pkg::ST_RXNE;
                i2ccrb_pkg::OFS_TXDATA:
                    result.read_data = {{(i2ccrb_pkg::DATA_W - i2ccrb_pkg::TXB_W){1'b0}},
                                        txbyte_reg};
                default: ;
            endcase
        end
        status_next = st;
    end

    // Output register and skid stage
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_stall)
        begin
            // hold the output; park a new result in the skid register
            if (accept)
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_next       = result;
            out_valid_next = accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg      <= '0;
            ctrl2_reg      <= '0;
            oar1_reg       <= '0;
            oar2_reg       <= '0;
            timing_reg     <= '0;
            timeout_reg    <= '0;
            status_reg     <= i2ccrb_pkg::STATUS_RESET;
            txbyte_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ctrl1_reg   <= ctrl1_next;
                ctrl2_reg   <= ctrl2_next;
                oar1_reg    <= oar1_next;
                oar2_reg    <= oar2_next;
                timing_reg  <= timing_next;
                timeout_reg <= timeout_next;
                status_reg  <= status_next;
                txbyte_reg  <= txbyte_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTH
    // The skid stage fills only behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register valid while output register empty");

    // A read never raises the interrupt
    a_read_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == i2ccrb_pkg::REQ_READ) |-> !result.irq_raise)
        else $error("read access raised interrupt");

    // A transmit-data write leaves TXE and TXIS set
    a_tx_sets_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == i2ccrb_pkg::REQ_WRITE
         && req.reg_offset == i2ccrb_pkg::OFS_TXDATA)
        |=> (status_reg[1:0] == 2'b11))
        else $error("transmit write did not set TXE and TXIS");

    // A result presented under stall holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_stall |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result changed");
`endif

endmodule
